/* rtl/core/crc32c_sample_block_key_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the CRC-32C sample block key unit.
// Define NO_ASSERTIONS to remove every checker from the build.
// ---------------------------------------------------------------------------
`ifndef CRC32C_SAMPLE_BLOCK_KEY_UNIT_MACROS_SVH
`define CRC32C_SAMPLE_BLOCK_KEY_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked property, switched off while reset is asserted.
`define CSKEY_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked property that also holds during reset.
`define CSKEY_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CSKEY_ASSERT(lbl, clk, rstn, prop, msg)
`define CSKEY_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/core/cskey_pkg.sv */
// ---------------------------------------------------------------------------
// cskey_pkg
// Shared constants, the transaction type and the CRC-32C byte update.
// ---------------------------------------------------------------------------
`default_nettype none

package cskey_pkg;

  // Field widths.
  localparam int unsigned SampleW = 16;
  localparam int unsigned KeyW    = 32;

  // Default number of sample bytes folded in per transaction.
  localparam int unsigned SampleBytesDef = 2;

  // Reset value of the seed register.
  localparam logic [KeyW-1:0] SeedReset = 32'h0000_01FF;

  // Reflected CRC-32C (Castagnoli) polynomial.
  localparam logic [KeyW-1:0] CrcPoly = 32'h82F6_3B78;

  // One input transaction held in the input register.
  typedef struct packed {
    logic               valid;
    logic [SampleW-1:0] sample;
    logic               start;
    logic               last;
  } item_t;

  // Fold one byte into a reflected CRC, one bit a step.
  function automatic logic [KeyW-1:0] crc_byte(input logic [KeyW-1:0] crc_in,
                                               input logic [7:0]      data);
    logic [KeyW-1:0] crc;
    crc = crc_in ^ {{(KeyW-8){1'b0}}, data};
    for (int b = 0; b < 8; b++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/crc32c_sample_block_key_unit.sv */
// ---------------------------------------------------------------------------
// crc32c_sample_block_key_unit
// CRC-32C block key over a stream of 16-bit pixel samples.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake                Payload
//  input     in         in_valid_i / in_stall_o  sample_i, block_start_i, block_last_i
//  output    out        out_valid_o / out_stall_i block_key_o
//  config    in         seed_value_we_i          seed_value_i
//
//  One sample transaction is accepted per cycle while in_stall_o is low; the CRC update
//  is combinational between the input register and the running CRC register.
//  A key is registered in the output stage once its last sample leaves the input register.
//  Reset loads the seed with 0x1FF and clears the running CRC; no clearing pass.
//  A stalled output only holds back the input once a further last sample waits.
// ---------------------------------------------------------------------------
`default_nettype none
`include "crc32c_sample_block_key_unit_macros.svh"

module crc32c_sample_block_key_unit #(
  parameter int unsigned SampleBytes = cskey_pkg::SampleBytesDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           seed_value_we_i,
  input  wire logic [cskey_pkg::KeyW-1:0]     seed_value_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [cskey_pkg::SampleW-1:0]  sample_i,
  input  wire logic                           block_start_i,
  input  wire logic                           block_last_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [cskey_pkg::KeyW-1:0]          block_key_o
);

  cskey_pkg::item_t           item;
  logic                       out_ready;
  logic                       move;
  logic                       key_load;
  logic [cskey_pkg::KeyW-1:0] crc_next;
  logic [cskey_pkg::KeyW-1:0] running_crc;

  // A transaction leaves the input register unless its key has nowhere to go.
  assign move     = item.valid && (!item.last || out_ready);
  assign key_load = move && item.last;

  cskey_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .block_start_i (block_start_i),
    .block_last_i  (block_last_i),
    .pop_i         (move),
    .item_o        (item)
  );

  cskey_crc_stage #(
    .SampleBytes (SampleBytes)
  ) u_crc_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .seed_value_we_i (seed_value_we_i),
    .seed_value_i    (seed_value_i),
    .item_i          (item),
    .step_i          (move),
    .crc_next_o      (crc_next),
    .running_crc_o   (running_crc)
  );

  cskey_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (key_load),
    .key_i       (crc_next),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .block_key_o (block_key_o)
  );

  // Checks on the hand-over between the stages.
  `CSKEY_ASSERT(a_key_not_overwritten, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |-> !key_load, "key overwritten while stalled")
  `CSKEY_ASSERT(a_crc_only_on_move, clk_i, rst_ni,
    !move |=> $stable(running_crc), "running CRC changed without a transaction")
  `CSKEY_ASSERT(a_key_matches_crc, clk_i, rst_ni,
    key_load |=> (out_valid_o && block_key_o == running_crc), "key differs from running CRC")
  `CSKEY_ASSERT_ALWAYS(a_stall_needs_item, clk_i,
    in_stall_o |-> item.valid, "input stalled with an empty register")

endmodule

`default_nettype wire

/* rtl/core/cskey_in_stage.sv */
// ---------------------------------------------------------------------------
// cskey_in_stage
// Input register for sample transactions, with stall towards the source.
// ---------------------------------------------------------------------------
`default_nettype none

module cskey_in_stage (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [cskey_pkg::SampleW-1:0]  sample_i,
  input  wire logic                           block_start_i,
  input  wire logic                           block_last_i,
  input  wire logic                           pop_i,
  output cskey_pkg::item_t                    item_o
);

  logic                          valid_q, valid_d;
  logic [cskey_pkg::SampleW-1:0] sample_q;
  logic                          start_q;
  logic                          last_q;
  logic                          load;

  // The register takes a new transaction when empty or when its content leaves.
  assign in_stall_o = valid_q && !pop_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  // Occupancy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, loaded only with a new transaction.
  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= sample_i;
      start_q  <= block_start_i;
      last_q   <= block_last_i;
    end
  end

  assign item_o = '{valid: valid_q, sample: sample_q, start: start_q, last: last_q};

endmodule

`default_nettype wire

/* rtl/core/cskey_crc_stage.sv */
// ---------------------------------------------------------------------------
// cskey_crc_stage
// Seed register, running CRC register and the CRC-32C sample update.
// ---------------------------------------------------------------------------
`default_nettype none

module cskey_crc_stage #(
  parameter int unsigned SampleBytes = cskey_pkg::SampleBytesDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        seed_value_we_i,
  input  wire logic [cskey_pkg::KeyW-1:0]  seed_value_i,
  input  wire cskey_pkg::item_t            item_i,
  input  wire logic                        step_i,
  output logic [cskey_pkg::KeyW-1:0]       crc_next_o,
  output logic [cskey_pkg::KeyW-1:0]       running_crc_o
);

  logic [cskey_pkg::KeyW-1:0] seed_q;
  logic [cskey_pkg::KeyW-1:0] crc_q, crc_d;

  // Seed register, written from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= cskey_pkg::SeedReset;
    end else if (seed_value_we_i) begin
      seed_q <= seed_value_i;
    end
  end

  // Start from the seed on a block start, then fold in the bytes low first.
  always_comb begin
    crc_d = item_i.start ? seed_q : crc_q;
    for (int i = 0; i < SampleBytes && i < 2; i++) begin
      crc_d = cskey_pkg::crc_byte(crc_d, item_i.sample[8*i +: 8]);
    end
  end

  // Running CRC advances once per transaction that leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else if (step_i) begin
      crc_q <= crc_d;
    end
  end

  assign crc_next_o    = crc_d;
  assign running_crc_o = crc_q;

endmodule

`default_nettype wire

/* rtl/core/cskey_out_stage.sv */
// ---------------------------------------------------------------------------
// cskey_out_stage
// Result register holding one block key until the sink takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module cskey_out_stage (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  wire logic [cskey_pkg::KeyW-1:0]  key_i,
  output logic                             ready_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [cskey_pkg::KeyW-1:0]       block_key_o
);

  logic                       valid_q, valid_d;
  logic [cskey_pkg::KeyW-1:0] key_q;

  // Free when empty or when the held key leaves in this cycle.
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Key payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q <= key_i;
    end
  end

  assign out_valid_o = valid_q;
  assign block_key_o = key_q;

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the CRC-32C block key unit against a behavioural predictor of the
// running CRC. Sample transactions are offered with random gaps, and keys are
// taken with random stalls and one long hold-off that backs up the input.
// The seed register is rewritten between phases, extremes included.
// ---------------------------------------------------------------------------
module testbench;

  localparam int unsigned KeyLatency  = 1;
  localparam int unsigned SettleCycles = KeyLatency + 6;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned IdlePct     = 37;
  localparam int unsigned MaxReports  = 10;

  // Predicts block keys from accepted sample transactions and checks the
  // keys that the unit hands out, oldest first.
  class key_scoreboard;
    logic [cskey_pkg::KeyW-1:0] seed;
    logic [cskey_pkg::KeyW-1:0] crc;
    logic [cskey_pkg::KeyW-1:0] keys_due[$];
    int unsigned                keys_total;
    int unsigned                mismatches;

    function new();
      seed       = cskey_pkg::SeedReset;
      crc        = '0;
      keys_total = 0;
      mismatches = 0;
    endfunction

    function void load_seed(input logic [cskey_pkg::KeyW-1:0] value);
      seed = value;
    endfunction

    // Reflected CRC-32C update over one byte, one bit per step.
    function logic [cskey_pkg::KeyW-1:0] fold_byte(input logic [cskey_pkg::KeyW-1:0] acc,
                                                   input logic [7:0]                 data);
      logic [cskey_pkg::KeyW-1:0] r;
      r = acc ^ {24'h0, data};
      for (int b = 0; b < 8; b++) begin
        r = r[0] ? ((r >> 1) ^ 32'h82F6_3B78) : (r >> 1);
      end
      return r;
    endfunction

    function void note_sample(input logic [cskey_pkg::SampleW-1:0] smp,
                              input logic is_first, input logic is_last);
      logic [cskey_pkg::KeyW-1:0] acc;
      acc = is_first ? seed : crc;
      for (int i = 0; i < cskey_pkg::SampleBytesDef; i++) begin
        acc = fold_byte(acc, smp[8*i +: 8]);
      end
      crc = acc;
      if (is_last) begin
        keys_due.push_back(acc);
        keys_total++;
      end
    endfunction

    function void check_key(input logic [cskey_pkg::KeyW-1:0] key);
      logic [cskey_pkg::KeyW-1:0] want;
      if (keys_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("block key mismatch: expected no key, actual %08h", key);
        end
      end else begin
        want = keys_due.pop_front();
        if (key !== want) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("block key mismatch: expected %08h, actual %08h", want, key);
          end
        end
      end
    endfunction

    function int unsigned pending();
      return keys_due.size();
    endfunction
  endclass

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          seed_value_we_i = 1'b0;
  logic [cskey_pkg::KeyW-1:0]    seed_value_i    = '0;
  logic                          in_valid_i      = 1'b0;
  logic                          in_stall_o;
  logic [cskey_pkg::SampleW-1:0] sample_i        = '0;
  logic                          block_start_i   = 1'b0;
  logic                          block_last_i    = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i     = 1'b0;
  logic [cskey_pkg::KeyW-1:0]    block_key_o;

  key_scoreboard sb;
  int unsigned   tx_idle_pct   = IdlePct;
  int unsigned   rx_idle_pct   = IdlePct;
  bit            hold_off_req  = 1'b0;

  crc32c_sample_block_key_unit #(
    .SampleBytes(cskey_pkg::SampleBytesDef)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .seed_value_we_i(seed_value_we_i),
    .seed_value_i   (seed_value_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .block_start_i  (block_start_i),
    .block_last_i   (block_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .block_key_o    (block_key_o)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Offer one sample transaction after a random gap and wait until it is taken.
  task automatic push_sample(input logic [cskey_pkg::SampleW-1:0] smp,
                             input logic is_first, input logic is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_i      <= smp;
    block_start_i <= is_first;
    block_last_i  <= is_last;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    sb.note_sample(smp, is_first, is_last);
  endtask

  // Drop the input and let every outstanding key drain, then wait out
  // a sample still inside the pipeline that produces no key.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [cskey_pkg::KeyW-1:0] value);
    settle();
    seed_value_we_i <= 1'b1;
    seed_value_i    <= value;
    @(posedge clk_i);
    seed_value_we_i <= 1'b0;
    sb.load_seed(value);
  endtask

  // Mostly well-formed blocks with random samples; some stray samples with
  // random flags and some blocks abandoned before their last sample.
  task automatic random_traffic(input int unsigned n_items, input int unsigned n_keys);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int unsigned keys_at_start;
    sent          = 0;
    keys_at_start = sb.keys_total;
    while (sent < n_items || sb.keys_total - keys_at_start < n_keys) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        push_sample(16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        sent++;
      end else begin
        case ($urandom_range(9))
          0, 1, 2: len = 1;
          3, 4, 5: len = 24;
          default: len = $urandom_range(8, 2);
        endcase
        for (int i = 0; i < len; i++) begin
          push_sample(16'($urandom_range(16'hFFFF)), i == 0,
                      (i == len - 1) && (kind >= 20));
        end
        sent += len;
      end
    end
  endtask

  // Key sink: takes keys with random stalls, and holds off for a long
  // stretch when asked so that the unit backs up into its input.
  initial begin : key_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_key(block_key_o);
      end
      if (hold_off_req) begin
        hold_left    = HoldCycles;
        hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Run limit.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [cskey_pkg::KeyW-1:0] seeds[5];
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Samples before any start carry on from the cleared CRC.
    push_sample(16'h1234, 1'b0, 1'b0);
    push_sample(16'hABCD, 1'b0, 1'b1);
    // After a key the CRC keeps running into the next sample.
    push_sample(16'hFFFF, 1'b0, 1'b1);
    // One-sample blocks at the sample extremes and alternating bits.
    push_sample(16'h0000, 1'b1, 1'b1);
    push_sample(16'hFFFF, 1'b1, 1'b1);
    push_sample(16'hAAAA, 1'b1, 1'b1);
    push_sample(16'h5555, 1'b1, 1'b1);
    // A short block, byte order visible through asymmetric samples.
    push_sample(16'h8001, 1'b1, 1'b0);
    push_sample(16'h00FF, 1'b0, 1'b0);
    push_sample(16'hFF00, 1'b0, 1'b0);
    push_sample(16'h5AA5, 1'b0, 1'b1);
    // A block restarted before its last sample.
    push_sample(16'h0001, 1'b1, 1'b0);
    push_sample(16'h0002, 1'b1, 1'b0);
    push_sample(16'h0100, 1'b0, 1'b1);

    seeds[0] = '0;
    seeds[1] = '1;
    seeds[2] = $urandom();
    seeds[3] = cskey_pkg::SeedReset;
    seeds[4] = $urandom();
    for (int p = 0; p < 5; p++) begin
      write_seed(seeds[p]);
      // One phase runs both sides flat out.
      tx_idle_pct = (p == 2) ? 0 : IdlePct;
      rx_idle_pct = (p == 2) ? 0 : IdlePct;
      random_traffic(60, 5);
      if (p == 3) begin
        // Long hold-off on the key side while single-sample blocks keep coming.
        tx_idle_pct  = 0;
        hold_off_req = 1'b1;
        for (int i = 0; i < 40; i++) begin
          push_sample(16'($urandom_range(16'hFFFF)), 1'b1, 1'b1);
        end
        tx_idle_pct = IdlePct;
      end
    end

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
